// ===== src/cscl_pkg.sv =====
`default_nettype none
package cscl_pkg;

  localparam int ELEM_W = 16;
  localparam int ID_W   = 20;
  localparam int ACC_W  = 42;
  localparam int PROD_W = 2 * ACC_W;
  localparam int SRCH_W = 120;
  localparam int SIM_W  = 17;
  localparam int CNT_W  = 6;
  localparam int BIT_W  = 5;

  localparam logic [SIM_W-1:0] ONE_Q16  = SIM_W'(65536);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(ACC_W - 1);
  localparam logic [CNT_W-1:0] SRCH_TOP = CNT_W'(SIM_W - 1);

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_ONE,
    RES_SRCH
  } res_sel_t;

  typedef struct packed {
    logic             acc_en;
    logic             clear;
    logic             load_p;
    logic             load_d;
    logic             mul_step;
    logic             srch_init;
    logic             cand;
    logic             cmp;
    logic             out_load;
    logic [BIT_W-1:0] bit_idx;
    res_sel_t         res_sel;
  } cmd_t;

  typedef struct packed {
    logic fast;
    logic id_eq;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/cscl_datapath.sv =====
`default_nettype none
module cscl_datapath import cscl_pkg::*; (
  input  wire                      clk,
  input  wire cmd_t                cmd,
  output sts_t                     sts,
  input  wire logic signed [ELEM_W-1:0] elem_a,
  input  wire logic signed [ELEM_W-1:0] elem_b,
  input  wire logic [ID_W-1:0]     id_a,
  input  wire logic [ID_W-1:0]     id_b,
  input  wire logic                found_a,
  input  wire logic                found_b,
  output logic [SIM_W-1:0]         similarity,
  output logic                     pair_found
);

  logic signed [ACC_W-1:0] dot_acc;
  logic [ACC_W-1:0]        norm_a_acc;
  logic [ACC_W-1:0]        norm_b_acc;
  logic                    id_eq;
  logic                    both;

  logic signed [2*ELEM_W-1:0] pab;
  logic signed [2*ELEM_W-1:0] paa;
  logic signed [2*ELEM_W-1:0] pbb;
  logic signed [ACC_W:0]      dot_sum;
  logic [ACC_W:0]             na_sum;
  logic [ACC_W:0]             nb_sum;
  logic signed [ACC_W-1:0]    dot_next;
  logic [ACC_W-1:0]           norm_a_next;
  logic [ACC_W-1:0]           norm_b_next;

  logic [PROD_W-1:0] mul_a;
  logic [ACC_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] p_reg;
  logic [SRCH_W-1:0] d_reg;
  logic [SRCH_W-1:0] s_acc;
  logic [SRCH_W-1:0] t_acc;
  logic [SRCH_W-1:0] cand_reg;
  logic [SIM_W-1:0]  r_reg;
  logic [SIM_W-1:0]  r_clamp;
  logic [CNT_W-1:0]  t_shift;
  logic [CNT_W-1:0]  p_shift;

  assign pab = elem_a * elem_b;
  assign paa = elem_a * elem_a;
  assign pbb = elem_b * elem_b;

  assign dot_sum = (ACC_W+1)'(pab) + (ACC_W+1)'(dot_acc);
  assign na_sum  = {1'b0, norm_a_acc} + (ACC_W+1)'(unsigned'(paa));
  assign nb_sum  = {1'b0, norm_b_acc} + (ACC_W+1)'(unsigned'(pbb));

  always_comb begin
    if (dot_sum[ACC_W] != dot_sum[ACC_W-1]) begin
      dot_next = dot_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      dot_next = dot_sum[ACC_W-1:0];
    end
    norm_a_next = na_sum[ACC_W] ? {ACC_W{1'b1}} : na_sum[ACC_W-1:0];
    norm_b_next = nb_sum[ACC_W] ? {ACC_W{1'b1}} : nb_sum[ACC_W-1:0];
  end

  assign sts.id_eq = id_eq;
  assign sts.fast  = id_eq || !both || dot_acc[ACC_W-1] || (dot_acc == '0)
                     || (norm_a_acc == '0) || (norm_b_acc == '0);

  assign t_shift = {1'b0, cmd.bit_idx} + CNT_W'(1);
  assign p_shift = {cmd.bit_idx, 1'b0};
  assign r_clamp = (r_reg > ONE_Q16) ? ONE_Q16 : r_reg;

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      dot_acc    <= '0;
      norm_a_acc <= '0;
      norm_b_acc <= '0;
    end else if (cmd.acc_en) begin
      dot_acc    <= dot_next;
      norm_a_acc <= norm_a_next;
      norm_b_acc <= norm_b_next;
      id_eq      <= (id_a == id_b);
      both       <= found_a && found_b;
    end

    if (cmd.load_p) begin
      mul_a <= PROD_W'(norm_a_acc);
      mul_b <= norm_b_acc;
      prod  <= '0;
    end else if (cmd.load_d) begin
      p_reg <= prod;
      mul_a <= PROD_W'(unsigned'(dot_acc));
      mul_b <= unsigned'(dot_acc);
      prod  <= '0;
    end else if (cmd.mul_step) begin
      if (mul_b[0]) begin
        prod <= prod + mul_a;
      end
      mul_a <= mul_a << 1;
      mul_b <= mul_b >> 1;
    end

    if (cmd.srch_init) begin
      d_reg <= SRCH_W'(prod) << 32;
      s_acc <= '0;
      t_acc <= '0;
      r_reg <= '0;
    end else if (cmd.cand) begin
      cand_reg <= s_acc + (t_acc << t_shift) + (SRCH_W'(p_reg) << p_shift);
    end else if (cmd.cmp) begin
      if (cand_reg <= d_reg) begin
        s_acc               <= cand_reg;
        t_acc               <= t_acc + (SRCH_W'(p_reg) << cmd.bit_idx);
        r_reg[cmd.bit_idx]  <= 1'b1;
      end
    end

    if (cmd.out_load) begin
      case (cmd.res_sel)
        RES_ONE:  similarity <= ONE_Q16;
        RES_SRCH: similarity <= r_clamp;
        default:  similarity <= '0;
      endcase
      pair_found <= both;
    end
  end

endmodule
`default_nettype wire

// ===== src/cscl_ctrl.sv =====
`default_nettype none
module cscl_ctrl import cscl_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        last_elem,
  output logic       out_valid,
  input  wire        out_ready,
  input  wire sts_t  sts,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_ACC,
    S_CHECK,
    S_MUL_P,
    S_LOAD_D,
    S_MUL_D,
    S_CAND,
    S_CMP,
    S_WRITE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  res_sel_t         res_sel;
  logic             out_free;

  assign in_ready = (state == S_ACC);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.bit_idx   = cnt[BIT_W-1:0];
    cmd.res_sel   = res_sel;
    cmd.acc_en    = in_valid && in_ready;
    cmd.load_p    = (state == S_CHECK) && !sts.fast;
    cmd.mul_step  = (state == S_MUL_P) || (state == S_MUL_D);
    cmd.load_d    = (state == S_LOAD_D);
    cmd.srch_init = (state == S_MUL_D) && (cnt == MUL_LAST);
    cmd.cand      = (state == S_CAND);
    cmd.cmp       = (state == S_CMP);
    cmd.out_load  = (state == S_WRITE) && out_free;
    cmd.clear     = cmd.out_load || rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACC;
      cnt       <= '0;
      res_sel   <= RES_ZERO;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_ACC: begin
          if (in_valid && last_elem) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          cnt <= '0;
          if (sts.id_eq) begin
            res_sel <= RES_ONE;
            state   <= S_WRITE;
          end else if (sts.fast) begin
            res_sel <= RES_ZERO;
            state   <= S_WRITE;
          end else begin
            res_sel <= RES_SRCH;
            state   <= S_MUL_P;
          end
        end
        S_MUL_P: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == MUL_LAST) begin
            state <= S_LOAD_D;
          end
        end
        S_LOAD_D: begin
          cnt   <= '0;
          state <= S_MUL_D;
        end
        S_MUL_D: begin
          if (cnt == MUL_LAST) begin
            cnt   <= SRCH_TOP;
            state <= S_CAND;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_CAND: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (cnt == '0) begin
            state <= S_WRITE;
          end else begin
            cnt   <= cnt - CNT_W'(1);
            state <= S_CAND;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            state <= S_ACC;
          end
        end
        default: state <= S_ACC;
      endcase
    end
  end

  a_last_goes_check: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_elem |=> state == S_CHECK)
    else $error("last transaction did not start the finish");

  a_write_sets_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE && out_free |=> out_valid && state == S_ACC)
    else $error("result not presented after write");

  a_search_ends: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP && cnt == '0 |=> state == S_WRITE)
    else $error("search did not end at bit zero");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_ACC |-> !cmd.acc_en)
    else $error("transaction accepted while finishing");

endmodule
`default_nettype wire

// ===== src/cosine_similarity_clamped.sv =====
// Finish: after the last transaction, a shortcut result (equal ids, missing
// vector, zero norm, non-positive dot) goes through S_CHECK and S_WRITE.
// Throughput: one element pair per cycle while summing; the finish then takes
// the serial 42-step multiplier twice and a 17-bit search (S_CAND, S_CMP per bit).
// Reset: synchronous; clears the controller and output valid, sums start at zero.
`default_nettype none
module cosine_similarity_clamped import cscl_pkg::*; (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire logic signed [ELEM_W-1:0] elem_a,
  input  wire logic signed [ELEM_W-1:0] elem_b,
  input  wire logic                 last_elem,
  input  wire logic [ID_W-1:0]      id_a,
  input  wire logic [ID_W-1:0]      id_b,
  input  wire logic                 found_a,
  input  wire logic                 found_b,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic [SIM_W-1:0]          similarity,
  output logic                      pair_found
);

  cmd_t cmd;
  sts_t sts;

  cscl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last_elem (last_elem),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cscl_datapath u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .sts        (sts),
    .elem_a     (elem_a),
    .elem_b     (elem_b),
    .id_a       (id_a),
    .id_b       (id_b),
    .found_a    (found_a),
    .found_b    (found_b),
    .similarity (similarity),
    .pair_found (pair_found)
  );

endmodule
`default_nettype wire

// ===== tb/cosine_similarity_clamped_tb.sv =====
`default_nettype none
module cosine_similarity_clamped_tb;
  import cscl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class cosine_scoreboard;
    longint          dot_sum;
    longint unsigned na_sum, nb_sum;
    logic [SIM_W-1:0] sim_q[$];
    logic             found_q[$];
    int               errors, results, pairs;

    function new();
      dot_sum = 0; na_sum = 0; nb_sum = 0;
      errors = 0; results = 0; pairs = 0;
    endfunction

    function longint unsigned norm_sat(longint unsigned acc, longint unsigned sq);
      longint unsigned top;
      top = (64'd1 << 42) - 1;
      if (sq > top - acc) return top;
      return acc + sq;
    endfunction

    function logic [SIM_W-1:0] cosine_q16();
      logic [127:0] bound, prod, trial;
      longint unsigned lo, hi, r;
      if (dot_sum <= 0 || na_sum == 0 || nb_sum == 0) return '0;
      bound = (128'(dot_sum) * 128'(dot_sum)) << 32;
      prod  = 128'(na_sum) * 128'(nb_sum);
      lo = 0;
      hi = 65536;
      while (lo < hi) begin
        r = (lo + hi + 1) >> 1;
        trial = prod * 128'(r * r);
        if (trial <= bound) lo = r;
        else hi = r - 1;
      end
      return SIM_W'(lo);
    endfunction

    function void note_input(logic signed [ELEM_W-1:0] a, logic signed [ELEM_W-1:0] b,
                             logic last, logic [ID_W-1:0] ida, logic [ID_W-1:0] idb,
                             logic fa, logic fb);
      longint pa, pb, d, dmax;
      logic [SIM_W-1:0] sim;
      pa = a;
      pb = b;
      dmax = (64'sd1 <<< 41) - 1;
      d = dot_sum + pa * pb;
      if (d > dmax) d = dmax;
      if (d < -dmax - 1) d = -dmax - 1;
      dot_sum = d;
      na_sum = norm_sat(na_sum, longint'(pa * pa));
      nb_sum = norm_sat(nb_sum, longint'(pb * pb));
      pairs++;
      if (!last) return;
      if (ida == idb) sim = ONE_Q16;
      else if (!(fa && fb)) sim = '0;
      else sim = cosine_q16();
      sim_q = {sim_q, sim};
      found_q = {found_q, fa && fb};
      dot_sum = 0; na_sum = 0; nb_sum = 0;
    endfunction

    function void check_result(logic [SIM_W-1:0] sim, logic found);
      logic [SIM_W-1:0] exp_sim;
      logic             exp_found;
      results++;
      if (sim_q.size() == 0) begin
        $display("%0t: unexpected result similarity=%0d pair_found=%0b", $time, sim, found);
        errors++;
        return;
      end
      exp_sim = sim_q.pop_front();
      exp_found = found_q.pop_front();
      if (sim !== exp_sim) begin
        $display("%0t: similarity expected %0d actual %0d", $time, exp_sim, sim);
        errors++;
      end
      if (found !== exp_found) begin
        $display("%0t: pair_found expected %0b actual %0b", $time, exp_found, found);
        errors++;
      end
    endfunction

    function int pending();
      return sim_q.size();
    endfunction
  endclass

  logic                     clk = 0;
  logic                     rst = 1;
  logic                     in_valid = 0;
  logic                     in_ready;
  logic signed [ELEM_W-1:0] elem_a = '0;
  logic signed [ELEM_W-1:0] elem_b = '0;
  logic                     last_elem = 0;
  logic [ID_W-1:0]          id_a = '0;
  logic [ID_W-1:0]          id_b = '0;
  logic                     found_a = 0;
  logic                     found_b = 0;
  logic                     out_valid;
  logic                     out_ready = 0;
  logic [SIM_W-1:0]         similarity;
  logic                     pair_found;

  cosine_scoreboard sb = new();
  bit  tx_busy_free = 0;
  bit  rx_busy_free = 0;
  bit  rx_hold = 0;
  int  cycles = 0;

  cosine_similarity_clamped uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .elem_a(elem_a), .elem_b(elem_b), .last_elem(last_elem),
    .id_a(id_a), .id_b(id_b), .found_a(found_a), .found_b(found_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .similarity(similarity), .pair_found(pair_found)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_input(elem_a, elem_b, last_elem, id_a, id_b, found_a, found_b);
      if (out_valid && out_ready)
        sb.check_result(similarity, pair_found);
    end
  end

  task automatic send_pair(logic signed [ELEM_W-1:0] a, logic signed [ELEM_W-1:0] b,
                           logic last, logic [ID_W-1:0] ida, logic [ID_W-1:0] idb,
                           logic fa, logic fb);
    int gap;
    gap = tx_busy_free ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1;
    elem_a    <= a;
    elem_b    <= b;
    last_elem <= last;
    id_a      <= ida;
    id_b      <= idb;
    found_a   <= fa;
    found_b   <= fb;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic signed [ELEM_W-1:0] rand_elem(int kind);
    case (kind)
      0: return ELEM_W'($urandom);
      1: return ELEM_W'($urandom_range(0, 255)) - 16'sd128;
      2: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      default: return '0;
    endcase
  endfunction

  // kind 3 makes b a copy of a plus a small offset so that the result lands near 1.0
  task automatic send_vector(int len, int kind, logic [ID_W-1:0] ida,
                             logic [ID_W-1:0] idb, logic fa, logic fb);
    logic signed [ELEM_W-1:0] a, b;
    for (int i = 0; i < len; i++) begin
      if (kind == 3) begin
        a = rand_elem(0) >>> 2;
        b = a + ELEM_W'($urandom_range(0, 15));
      end else begin
        a = rand_elem($urandom_range(0, 2) == 0 ? kind : $urandom_range(0, 2));
        b = rand_elem($urandom_range(0, 2) == 0 ? kind : $urandom_range(0, 2));
      end
      send_pair(a, b, i == len - 1, ida, idb, fa, fb);
    end
  endtask

  initial begin
    int n;
    wait (!rst);
    forever begin
      if (rx_hold) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        rx_hold = 0;
      end
      n = rx_busy_free ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int len, kind, sent;
    bit held, drained;
    logic [ID_W-1:0] ida, idb;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_pair(16'sh7fff, 16'sh7fff, 1, 20'h00001, 20'h00002, 1, 1);
    send_pair(16'sh8000, 16'sh8000, 1, 20'hfffff, 20'h00000, 1, 1);
    send_pair(16'sh7fff, 16'sh8000, 1, 20'h00003, 20'h00004, 1, 1);
    send_pair(16'sh0000, 16'sh1000, 1, 20'h00005, 20'h00006, 1, 1);
    send_pair(16'sh1000, 16'sh0000, 1, 20'h00005, 20'h00006, 1, 1);
    send_pair(16'sh1000, 16'sh1000, 1, 20'h00007, 20'h00008, 0, 1);
    send_pair(16'sh1000, 16'sh1000, 1, 20'h00009, 20'h0000a, 1, 0);
    send_pair(16'sh8000, 16'sh7fff, 1, 20'h12345, 20'h12345, 0, 0);
    send_pair(16'sh0000, 16'sh0000, 1, 20'h54321, 20'h54321, 1, 1);
    send_pair(16'sh1000, 16'sh0000, 0, 20'h00001, 20'h00002, 1, 1);
    send_pair(16'sh0000, 16'sh1000, 1, 20'h00001, 20'h00002, 1, 1);
    send_pair(16'sh1000, 16'sh1000, 0, 20'h00001, 20'h00002, 1, 1);
    send_pair(16'sh1000, -16'sh1000, 1, 20'h00001, 20'h00002, 1, 1);
    send_pair(16'sh0001, 16'sh0003, 0, 20'haaaaa, 20'h55555, 1, 1);
    send_pair(16'sh0002, 16'sh0001, 1, 20'haaaaa, 20'h55555, 1, 1);
    send_pair(16'sh0001, 16'sh7fff, 1, 20'h00010, 20'h00011, 1, 1);

    in_valid <= 0;
    while (sb.pending() != 0) @(posedge clk);

    // full-scale vector of the longest length
    tx_busy_free = 1;
    for (int i = 0; i < 512; i++)
      send_pair(16'sh8000, (i % 3 == 0) ? 16'sh7fff : 16'sh8000, i == 511,
                20'h00100, 20'h00200, 1, 1);
    tx_busy_free = 0;

    sent = 0;
    held = 0;
    drained = 0;
    while (sent < 1380) begin
      if (!held && sent > 600) begin
        held = 1;
        rx_hold = 1;
        tx_busy_free = 1;
        repeat (8) send_vector(5, 1, 20'h00001, 20'h00002, 1, 1);
        tx_busy_free = 0;
        sent += 40;
        in_valid <= 0;
        while (sb.pending() != 0) @(posedge clk);
      end
      if (!drained && sent > 1000) begin
        drained = 1;
        in_valid <= 0;
        while (sb.pending() != 0) @(posedge clk);
      end
      tx_busy_free = ($urandom_range(0, 3) == 0);
      rx_busy_free = ($urandom_range(0, 4) == 0);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      kind = $urandom_range(0, 3);
      ida  = ID_W'($urandom);
      idb  = ($urandom_range(0, 7) == 0) ? ida : ID_W'($urandom);
      send_vector(len, kind, ida, idb, $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0);
      sent += len;
    end
    tx_busy_free = 0;
    rx_busy_free = 0;
    in_valid <= 0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d element pairs and %0d similarity results,", sb.pairs, sb.results);
    $display("including full-scale sums, shortcut cases and back-pressure; %0d errors.",
             sb.errors);
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
